@@ src/bsa_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the band steering admission block
// no dependencies

package bsa_pkg;

  // station table geometry
  localparam int unsigned NUM_STATIONS = 256;
  localparam int unsigned IDX_W        = $clog2(NUM_STATIONS);

  // auth attempt that finally passes for a 5 GHz capable station
  localparam logic [2:0] AUTH_PASS_TRY = 3'd3;

  // saturation value of the probe counter
  localparam logic [7:0] PROBE_CNT_MAX = 8'hFF;

  // configuration register reset values
  localparam logic        STEER_ENABLE_RST = 1'b0;
  localparam logic [9:0]  ASSOC_LIMIT_RST  = 10'd32;
  localparam logic [31:0] IDENT_WIN_RST    = 32'd1000;
  localparam logic [7:0]  DISCARD_LIM_RST  = 8'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_STEER_ENABLE = 2'd0,
    CFG_ASSOC_LIMIT  = 2'd1,
    CFG_IDENT_WINDOW = 2'd2,
    CFG_DISCARD_LIM  = 2'd3
  } cfg_idx_e;

  // management frame kinds
  typedef enum logic [1:0] {
    ACT_PROBE = 2'd0,
    ACT_AUTH  = 2'd1,
    ACT_OTHER = 2'd2
  } action_e;

  // input item
  typedef struct packed {
    logic [7:0]  station_index;
    logic        new_station;
    logic        station_known;
    logic [1:0]  action;
    logic        rx_band_5g;
    logic        peer_same_essid;
    logic        peer_band_5g;
    logic [9:0]  own_assoc_count;
    logic [9:0]  peer_assoc_count;
    logic        addressed_to_us;
    logic [31:0] now_ms;
    logic [31:0] first_seen_ms;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       allow;
    logic       identified;
    logic [1:0] station_caps;
  } out_item_t;

  // one station table entry
  typedef struct packed {
    logic       ident_done;
    logic [7:0] probe_count;
    logic [1:0] band_caps;
    logic [1:0] auth_retry_count;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // latch input item and read its table entry
    logic commit;  // write back entry and register the result
  } dp_cmd_t;

endpackage

@@ src/band_steering_admission_core.sv @@
`timescale 1ns / 1ps
// top level of band steering admission: controller plus datapath
// depends on bsa_pkg, bsa_ctrl, bsa_datapath
//
//   channel | signals                               | payload
//   --------+---------------------------------------+---------------------
//   in      | in_valid_i / in_ready_o               | in_data_i (in_item_t)
//   out     | out_valid_o / out_ready_i             | out_data_o (out_item_t)
//   cfg     | cfg_valid_i / cfg_ready_o             | cfg_index_i, cfg_data_i
//
// one item at a time: the transfer cycle reads the station table
// entry into a register, the calc state then updates it, writes it back
// and loads the result register before the next item is taken.
// reset clears configuration to defaults and marks every table entry
// invalid at once through per-entry valid bits; no clearing pass.
// a result waiting on out_ready_i holds the next item in its update cycle;
// an input transfer still happens while a result waits.
// cfg_ready_o is always high.

module band_steering_admission_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsa_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bsa_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // sequencing
  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // table and decision
  bsa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/bsa_ctrl.sv @@
`timescale 1ns / 1ps
// controller for band steering admission: sequences read, update and result
// depends on bsa_pkg

module bsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bsa_pkg::dp_cmd_t cmd_o
);
  import bsa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  state_e state_d, state_q;
  logic   out_valid_d, out_valid_q;
  logic   out_free;

  // result register can take a new item when empty or being drained
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.commit = (state_q == ST_CALC) && out_free;

  // next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // an accepted item is being worked on in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !cmd_o.load))
    else $error("input taken while an item is in flight");

  // a committed item always shows up as a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

  // load and commit never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.commit))
    else $error("load and commit in the same cycle");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_o.commit)
    else $error("result overwritten before transfer");

endmodule

@@ src/bsa_datapath.sv @@
`timescale 1ns / 1ps
// datapath for band steering admission: config registers, station table,
// admission decision and result register; depends on bsa_pkg

module bsa_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsa_pkg::dp_cmd_t  cmd_i,
  input  bsa_pkg::in_item_t in_data_i,
  input  logic              cfg_wr_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output bsa_pkg::out_item_t out_data_o
);
  import bsa_pkg::*;

  // configuration registers
  logic        steer_enable_q;
  logic [9:0]  assoc_limit_q;
  logic [31:0] ident_win_q;
  logic [7:0]  discard_lim_q;

  // station table and per-entry valid bits
  entry_t                    mem_q [NUM_STATIONS];
  logic [NUM_STATIONS-1:0]   vld_q;
  entry_t                    rd_q;
  logic                      rd_vld_q;
  in_item_t                  item_q;
  out_item_t                 out_q;

  logic [IDX_W-1:0] idx_in;
  logic [IDX_W-1:0] idx_q;
  entry_t           cur;
  entry_t           nxt;
  logic             allow;
  logic             gate;
  logic [31:0]      elapsed;
  logic [7:0]       pc_inc;
  logic [2:0]       retry;

  assign idx_in = in_data_i.station_index[IDX_W-1:0];
  assign idx_q  = item_q.station_index[IDX_W-1:0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_enable_q <= STEER_ENABLE_RST;
      assoc_limit_q  <= ASSOC_LIMIT_RST;
      ident_win_q    <= IDENT_WIN_RST;
      discard_lim_q  <= DISCARD_LIM_RST;
    end else if (cfg_wr_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEER_ENABLE: steer_enable_q <= cfg_data_i[0];
        CFG_ASSOC_LIMIT:  assoc_limit_q  <= cfg_data_i[9:0];
        CFG_IDENT_WINDOW: ident_win_q    <= cfg_data_i;
        CFG_DISCARD_LIM:  discard_lim_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // table valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_vld_q <= vld_q[idx_in];
      end
      if (cmd_i.commit) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  // table memory, input latch and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      rd_q   <= mem_q[idx_in];
    end
    if (cmd_i.commit) begin
      mem_q[idx_q] <= nxt;
    end
  end

  // entry as seen by this step, cleared for a new station
  always_comb begin
    cur = rd_q;
    if (!rd_vld_q || item_q.new_station) begin
      cur = '0;
    end
  end

  // steering gate: same essid and a 5 GHz radio under the limit
  assign gate = item_q.peer_same_essid &&
                ((item_q.peer_band_5g && (item_q.peer_assoc_count < assoc_limit_q)) ||
                 (item_q.rx_band_5g && (item_q.own_assoc_count < assoc_limit_q)));

  assign elapsed = item_q.now_ms - item_q.first_seen_ms;
  assign pc_inc  = (cur.probe_count == PROBE_CNT_MAX) ? cur.probe_count
                                                      : cur.probe_count + 8'd1;
  assign retry   = {1'b0, cur.auth_retry_count} + 3'd1;

  // admission decision and entry update
  always_comb begin
    nxt   = cur;
    allow = 1'b1;
    if (!item_q.station_known) begin
      allow = 1'b0;
    end else if (!steer_enable_q || !gate ||
                 ((item_q.action != ACT_PROBE) && (item_q.action != ACT_AUTH))) begin
      allow = 1'b1;
    end else if (item_q.action == ACT_PROBE) begin
      if (item_q.rx_band_5g) begin
        nxt.band_caps[1] = 1'b1;
        nxt.ident_done   = 1'b1;
        allow            = 1'b1;
      end else if (!cur.ident_done) begin
        allow = 1'b0;
        if (elapsed <= ident_win_q) begin
          nxt.band_caps[0] = 1'b1;
          nxt.probe_count  = pc_inc;
          if (pc_inc >= discard_lim_q) begin
            nxt.ident_done = 1'b1;
          end
        end else begin
          // window expired: restart as a 2.4 GHz only station
          nxt.band_caps   = 2'b01;
          nxt.ident_done  = 1'b0;
          nxt.probe_count = '0;
        end
      end else if (cur.band_caps[1]) begin
        nxt.band_caps[0] = 1'b1;
        allow            = 1'b0;
      end else begin
        allow = 1'b1;
      end
    end else begin
      // authentication
      if (!item_q.addressed_to_us) begin
        allow = 1'b0;
      end else if (item_q.rx_band_5g) begin
        allow = 1'b1;
      end else if (!cur.ident_done) begin
        allow = 1'b0;
      end else if (cur.band_caps[1]) begin
        if (retry < AUTH_PASS_TRY) begin
          nxt.auth_retry_count = retry[1:0];
          allow                = 1'b0;
        end else begin
          nxt.auth_retry_count = '0;
          allow                = 1'b1;
        end
      end else begin
        allow = 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.allow        <= allow;
      out_q.identified   <= nxt.ident_done;
      out_q.station_caps <= nxt.band_caps;
    end
  end

  assign out_data_o = out_q;

  // an entry written back is marked valid from then on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> vld_q[$past(idx_q)])
    else $error("written entry not marked valid");

  // unknown stations are always dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !item_q.station_known) |=> !out_data_o.allow)
    else $error("unknown station passed");

  // with steering off every known station passes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && item_q.station_known && !steer_enable_q) |=> out_data_o.allow)
    else $error("frame dropped with steering off");

endmodule
